FILE: rtl/mrct_pkg.sv
// ----------------------------------------------------------------------------
// mrct_pkg
// shared types and constants of the mixed-radix countdown timer
// ----------------------------------------------------------------------------
package mrct_pkg;

  // input item kinds, carried on in_tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // configuration register indexes (paddr[2])
  localparam logic REG_FRAME_RATE_MODE = 1'b0;
  localparam logic REG_COUNT_ENABLE    = 1'b1;

  localparam logic [9:0] MAX_LOAD_SECONDS = 10'd599;

  // digit reload values on borrow
  localparam logic [3:0] RELOAD_DEC     = 4'd9;
  localparam logic [2:0] RELOAD_TENS_S  = 3'd5;
  localparam logic [2:0] RELOAD_TT_50HZ = 3'd4;
  localparam logic [2:0] RELOAD_TT_60HZ = 3'd5;

  typedef struct packed {
    logic [3:0] minutes;
    logic [2:0] tens_s;
    logic [3:0] secs;
    logic [2:0] tick_tens;
    logic [3:0] tick_units;
  } digits_t;

  // item held in the input register, load fields already split into digits
  typedef struct packed {
    logic       op;
    logic [3:0] ld_minutes;
    logic [2:0] ld_tens_s;
    logic [3:0] ld_secs;
    logic [9:0] ld_count;
  } item_t;

  typedef struct packed {
    logic frame_rate_mode;
    logic count_enable;
  } cfg_t;

  typedef struct packed {
    digits_t    dig;
    logic [9:0] count;
  } result_t;

endpackage

FILE: rtl/mrct_in_stage.sv
// ----------------------------------------------------------------------------
// mrct_in_stage
// input register; saturates a load time and splits it into digits
// ----------------------------------------------------------------------------
module mrct_in_stage
  import mrct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        advance,
  output logic        item_vld,
  output item_t       item
);

  logic        vld_r, vld_nxt;
  item_t       item_r, item_nxt;
  logic        accept;
  logic [9:0]  secs_sat;
  logic [19:0] min_prod;
  logic [3:0]  minutes;
  logic [9:0]  rem60_full;
  logic [5:0]  rem60;
  logic [13:0] tens_prod;
  logic [2:0]  tens_s;
  logic [5:0]  secs_full;

  assign in_tready = !vld_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    secs_sat   = (in_tdata[9:0] > MAX_LOAD_SECONDS) ? MAX_LOAD_SECONDS : in_tdata[9:0];
    // s / 60 as (s * 547) >> 15, exact for s up to 599
    min_prod   = 20'(secs_sat) * 20'd547;
    minutes    = min_prod[18:15];
    rem60_full = secs_sat - 10'(minutes) * 10'd60;
    rem60      = rem60_full[5:0];
    // r / 10 as (r * 26) >> 8, exact for r up to 59
    tens_prod  = 14'(rem60) * 14'd26;
    tens_s     = tens_prod[10:8];
    secs_full  = rem60 - 6'(tens_s) * 6'd10;

    item_nxt.op         = in_tuser;
    item_nxt.ld_minutes = minutes;
    item_nxt.ld_tens_s  = tens_s;
    item_nxt.ld_secs    = secs_full[3:0];
    item_nxt.ld_count   = secs_sat + 10'd1;

    if (accept) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

FILE: rtl/mrct_core.sv
// ----------------------------------------------------------------------------
// mrct_core
// second count and display digits with the borrow chain
// ----------------------------------------------------------------------------
module mrct_core
  import mrct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [9:0] count_r, count_nxt;
  digits_t    dig_r, dig_nxt;
  logic [9:0] count_dec;
  logic       b_tu, b_tt, b_sec, b_tens;

  always_comb begin
    count_nxt = count_r;
    dig_nxt   = dig_r;
    count_dec = count_r;
    b_tu      = 1'b0;
    b_tt      = 1'b0;
    b_sec     = 1'b0;
    b_tens    = 1'b0;

    if (item.op == OP_LOAD) begin
      count_nxt          = item.ld_count;
      dig_nxt.minutes    = item.ld_minutes;
      dig_nxt.tens_s     = item.ld_tens_s;
      dig_nxt.secs       = item.ld_secs;
      dig_nxt.tick_tens  = '0;
      dig_nxt.tick_units = '0;
    end else if (cfg.count_enable && count_r != '0) begin
      // a whole second goes when both tick digits sit at zero
      if (dig_r.tick_units == '0 && dig_r.tick_tens == '0) begin
        count_dec = count_r - 10'd1;
      end
      count_nxt = count_dec;
      // no digit change on the tick that runs out the time
      if (count_dec != '0) begin
        b_tu   = (dig_r.tick_units == '0);
        b_tt   = b_tu && (dig_r.tick_tens == '0);
        b_sec  = b_tt && (dig_r.secs == '0);
        b_tens = b_sec && (dig_r.tens_s == '0);

        dig_nxt.tick_units = b_tu ? RELOAD_DEC : dig_r.tick_units - 4'd1;
        if (b_tu) begin
          if (b_tt) begin
            dig_nxt.tick_tens = cfg.frame_rate_mode ? RELOAD_TT_60HZ : RELOAD_TT_50HZ;
          end else begin
            dig_nxt.tick_tens = dig_r.tick_tens - 3'd1;
          end
        end
        if (b_tt) begin
          dig_nxt.secs = b_sec ? RELOAD_DEC : dig_r.secs - 4'd1;
        end
        if (b_sec) begin
          dig_nxt.tens_s = b_tens ? RELOAD_TENS_S : dig_r.tens_s - 3'd1;
        end
        if (b_tens) begin
          dig_nxt.minutes = (dig_r.minutes == '0) ? RELOAD_DEC : dig_r.minutes - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      dig_r   <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
      dig_r   <= dig_nxt;
    end
  end

  // result shows the state after the item
  assign res.count = count_nxt;
  assign res.dig   = dig_nxt;

endmodule

FILE: rtl/mixed_radix_countdown_timer.sv
// ----------------------------------------------------------------------------
// mixed_radix_countdown_timer
// countdown timer shown as minutes, tens of seconds, seconds and tick digits
// ----------------------------------------------------------------------------
//  channel  | ports               | role
//  ---------+---------------------+-----------------------------------------
//  input    | in_t*               | tick or load item (tuser = kind)
//  result   | out_t*              | digits, second count and expiry per item
//  config   | cfg_p*              | frame rate mode, count enable
//
//  one item per cycle sustained while out_tready stays high; each item passes
//  the input register, then the result register, before its result is
//  offered
//  the digit borrow chain and second count update together in the core
//  reset (synchronous, rst_n low) clears the count and digits, so the
//  result of a tick right after reset reports expired
//  a stalled result holds in the output register while one more item waits
//  in the input register; the input side stalls only when both are full
// ----------------------------------------------------------------------------
module mixed_radix_countdown_timer
  import mrct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] load_seconds
  input  logic        in_tuser,   // [0] opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] minutes_digit, [6:4] tens_of_seconds, [10:7] seconds_digit,
  // [13:11] tick_tens, [17:14] tick_units, [27:18] seconds_left, [28] expired
  output logic [31:0] out_tdata,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t        cfg_r;
  logic        cfg_wr;
  logic        advance;
  logic        item_vld;
  item_t       item;
  logic        fire;
  result_t     res;
  logic        out_vld_r, out_vld_nxt;
  logic [31:0] out_data_r;
  logic [31:0] out_data_nxt;

  // configuration registers, always ready
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_FRAME_RATE_MODE: cfg_r.frame_rate_mode <= cfg_pwdata[0];
        REG_COUNT_ENABLE:    cfg_r.count_enable    <= cfg_pwdata[0];
        default:             cfg_r                 <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_FRAME_RATE_MODE: cfg_prdata = {31'd0, cfg_r.frame_rate_mode};
      REG_COUNT_ENABLE:    cfg_prdata = {31'd0, cfg_r.count_enable};
      default:             cfg_prdata = '0;
    endcase
  end

  // the item in the input register moves on whenever the result slot frees up
  assign advance = !out_vld_r || out_tready;
  assign fire    = item_vld && advance;

  mrct_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .item_vld  (item_vld),
    .item      (item)
  );

  mrct_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // result register
  always_comb begin
    out_data_nxt = {3'd0, (res.count == '0), res.count, res.dig.tick_units,
                    res.dig.tick_tens, res.dig.secs, res.dig.tens_s, res.dig.minutes};
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // expiry flag agrees with the second count
  a_expired_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[28] == (out_tdata[27:18] == 10'd0)))
    else $error("expired flag does not match seconds_left");

  // digits stay within their radix
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] <= 4'd9 && out_tdata[6:4] <= 3'd5 &&
                    out_tdata[10:7] <= 4'd9 && out_tdata[13:11] <= 3'd5 &&
                    out_tdata[17:14] <= 4'd9))
    else $error("display digit out of range");

  // second count never exceeds a saturated load plus one
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[27:18] <= 10'd600))
    else $error("seconds_left out of range");

  // an item waiting behind a stalled result is not dropped
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld && !advance) |=> item_vld)
    else $error("pending item lost while result stalled");

endmodule

FILE: sim/tb_mixed_radix_countdown_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mixed_radix_countdown_timer
// self-checking bench for the countdown timer: a directed opening covers
// saturated and disabled loads, expiry, frozen ticks and borrows into the
// minutes digit, then random load-and-countdown runs, counting on at both
// frame rates and off at 50 hz, with random stalls on both streams and one
// long result stall; each result is checked against a predicted display
// ----------------------------------------------------------------------------
module tb_mixed_radix_countdown_timer;
  import mrct_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;

  // one input item as the sender sees it
  typedef struct {
    logic       op;
    logic [9:0] secs;
  } timer_cmd_t;

  // what the block should show after one item
  typedef struct {
    digits_t    dig;
    logic [9:0] left;
    logic       expired;
  } timer_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = OP_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mixed_radix_countdown_timer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // commands waiting for the driver and displays waiting for the block
  timer_cmd_t  cmd_queue[$];
  timer_view_t predicted_views[$];

  // predictor state: own copy of the timer and of its two registers
  digits_t    timer_dig = '0;
  logic [9:0] timer_left = '0;
  logic       rate_60hz = 1'b0;
  logic       count_on = 1'b0;

  int tx_idle_pct = 10;
  int rx_idle_pct = 65;
  int mismatches = 0;
  int loads_sent = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int expired_seen = 0;
  int cycle_count = 0;

  logic hold_trig = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  timer_cmd_t cur_cmd;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: apply one accepted item and queue the display it must produce
  // ---------------------------------------------------------------------------
  task automatic advance_timer(input logic op, input logic [9:0] secs);
    int          s;
    timer_view_t view;
    if (op == OP_LOAD) begin
      // loads always land, enabled or not, saturated at the top of range
      s = (secs > MAX_LOAD_SECONDS) ? int'(MAX_LOAD_SECONDS) : int'(secs);
      timer_left = 10'(s + 1);
      timer_dig.tick_units = '0;
      timer_dig.tick_tens = '0;
      timer_dig.secs = 4'(s % 10);
      timer_dig.tens_s = 3'((s / 10) % 6);
      timer_dig.minutes = 4'(s / 60);
      loads_sent++;
    end else begin
      ticks_sent++;
      // frozen once expired; disabled ticks change nothing
      if (count_on && timer_left != 0) begin
        if (timer_dig.tick_units == 0 && timer_dig.tick_tens == 0) begin
          timer_left = timer_left - 10'd1;
        end
        // the tick that reaches zero leaves the digits alone
        if (timer_left != 0) begin
          if (timer_dig.tick_units != 0) begin
            timer_dig.tick_units--;
          end else begin
            timer_dig.tick_units = RELOAD_DEC;
            if (timer_dig.tick_tens != 0) begin
              timer_dig.tick_tens--;
            end else begin
              timer_dig.tick_tens = rate_60hz ? RELOAD_TT_60HZ : RELOAD_TT_50HZ;
              if (timer_dig.secs != 0) begin
                timer_dig.secs--;
              end else begin
                timer_dig.secs = RELOAD_DEC;
                if (timer_dig.tens_s != 0) begin
                  timer_dig.tens_s--;
                end else begin
                  timer_dig.tens_s = RELOAD_TENS_S;
                  // minutes wrap to nine when every digit was zero
                  if (timer_dig.minutes != 0) begin
                    timer_dig.minutes--;
                  end else begin
                    timer_dig.minutes = RELOAD_DEC;
                  end
                end
              end
            end
          end
        end
      end
    end
    view.dig = timer_dig;
    view.left = timer_left;
    view.expired = (timer_left == 0);
    predicted_views.push_back(view);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued commands, sender gaps drawn per cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        advance_timer(in_tuser, in_tdata[9:0]);
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_cmd = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_cmd.op;
          in_tdata <= {6'b0, cur_cmd.secs};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long result-side stall, counted here so the sender keeps pushing
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result transfer is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tdata[28]) begin
          expired_seen++;
        end
        if (predicted_views.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none actual %h", $time, out_tdata);
        end else begin
          // fields from the low end: minutes, tens of s, s, tick tens,
          // tick units, seconds left, expired
          check_field("minutes_digit", predicted_views[0].dig.minutes, out_tdata[3:0]);
          check_field("tens_of_seconds", predicted_views[0].dig.tens_s, out_tdata[6:4]);
          check_field("seconds_digit", predicted_views[0].dig.secs, out_tdata[10:7]);
          check_field("tick_tens", predicted_views[0].dig.tick_tens, out_tdata[13:11]);
          check_field("tick_units", predicted_views[0].dig.tick_units, out_tdata[17:14]);
          check_field("seconds_left", predicted_views[0].left, out_tdata[27:18]);
          check_field("expired", predicted_views[0].expired, out_tdata[28]);
          void'(predicted_views.pop_front());
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               predicted_views.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input logic op, input logic [9:0] secs);
    timer_cmd_t c;
    c.op = op;
    c.secs = secs;
    cmd_queue.push_back(c);
  endtask

  // idle means nothing queued, nothing offered and nothing in flight
  task automatic wait_drained();
    @(negedge clk);
    while (cmd_queue.size() != 0 || in_tvalid || predicted_views.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write one register (setup, then access) and read it back
  task automatic cfg_write(input logic idx, input logic val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {31'b0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    // write lands on this edge
    if (idx == REG_FRAME_RATE_MODE) begin
      rate_60hz = val;
    end else begin
      count_on = val;
    end
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {31'b0, val}) begin
      mismatches++;
      $display("%0t ns: register %0d readback mismatch, expected %0d actual %h", $time, idx,
               val, cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_mode(input logic rate, input logic en);
    wait_drained();
    cfg_write(REG_FRAME_RATE_MODE, rate);
    cfg_write(REG_COUNT_ENABLE, en);
    @(negedge clk);
  endtask

  // mostly a load followed by a countdown run long enough to expire for
  // short start times; runs cut short by the next load give broken sequences
  task automatic queue_countdown_runs(input int n_items);
    int added;
    int pick;
    int start_s;
    int run_len;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        start_s = $urandom_range(3);
      end else if (pick < 90) begin
        start_s = $urandom_range(20);
      end else begin
        start_s = $urandom_range(1023);
      end
      push_cmd(OP_LOAD, 10'(start_s));
      run_len = (start_s > 3) ? 300 : (start_s + 2) * 62;
      run_len = $urandom_range(run_len, 1);
      for (int i = 0; i < run_len; i++) begin
        // the seconds field is a don't-care on ticks, so it carries noise
        push_cmd(OP_TICK, 10'($urandom_range(1023)));
      end
      added += run_len + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // after reset: counting off, 50 hz, count at zero
    push_cmd(OP_TICK, 10'd0);
    push_cmd(OP_LOAD, 10'd0);
    push_cmd(OP_TICK, 10'h3ff);

    set_mode(1'b0, 1'b1);
    push_cmd(OP_TICK, 10'd0);       // one second left, this tick expires it
    push_cmd(OP_TICK, 10'd0);       // frozen after expiry
    push_cmd(OP_LOAD, 10'h3ff);     // saturates
    push_cmd(OP_TICK, 10'd0);
    push_cmd(OP_LOAD, 10'd600);
    push_cmd(OP_LOAD, 10'd599);
    push_cmd(OP_LOAD, 10'd60);
    push_cmd(OP_TICK, 10'd0);       // borrow ripples into the minutes digit
    push_cmd(OP_LOAD, 10'h2aa);
    push_cmd(OP_LOAD, 10'h155);
    push_cmd(OP_TICK, 10'h2aa);

    set_mode(1'b1, 1'b1);
    push_cmd(OP_LOAD, 10'd1);
    push_cmd(OP_TICK, 10'h155);     // tick tens reloads to the 60 hz value
    push_cmd(OP_TICK, 10'h3ff);

    set_mode(1'b1, 1'b0);
    push_cmd(OP_LOAD, 10'd5);       // load lands while counting is off
    push_cmd(OP_TICK, 10'd0);

    // random part, state carried across rate changes on purpose
    set_mode(1'b0, 1'b1);
    queue_countdown_runs(650);

    set_mode(1'b1, 1'b1);
    tx_idle_pct = 65;
    rx_idle_pct = 10;
    queue_countdown_runs(650);

    set_mode(1'b1, 1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_countdown_runs(550);
    // result side stops for a while so both registers fill and the input stalls
    @(posedge clk);
    hold_trig <= ~hold_trig;

    set_mode(1'b0, 1'b0);
    queue_countdown_runs(150);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d loads and %0d ticks at both frame rates, counting on and off,",
             loads_sent, ticks_sent);
    $display("%0d results checked, %0d of them showing an expired timer", results_seen,
             expired_seen);
    if (mismatches == 0 && predicted_views.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
